// ----- sv/lpo_pkg.sv -----
// shared constants for the dust sensor low-pulse occupancy meter
package lpo_pkg;

  localparam int unsigned WIN_W     = 26;
  localparam int unsigned LOW_W     = 26;
  localparam int unsigned RATIO_W   = 23;
  localparam int unsigned CONC_W    = 29;
  localparam int unsigned QUO_W     = 29;
  localparam int unsigned R2_W      = 30;
  localparam int unsigned R3_W      = 36;
  localparam int unsigned PROD_W    = R2_W + RATIO_W;
  localparam int unsigned S_W       = 40;
  localparam int unsigned U_W       = 31;
  localparam int unsigned FRAC_W    = 16;
  localparam int unsigned TDATA_O_W = 80;
  localparam int unsigned TDATA_I_W = 8;

  localparam logic [WIN_W-1:0]   WIN_RESET  = 26'd30000000;
  localparam logic [RATIO_W-1:0] PCT_Q16    = 23'd6553600;
  localparam logic [S_W-1:0]     OFFSET_Q16 = 40'd406323;
  localparam logic [S_W-1:0]     ROUND_HALF = 40'd1280;
  localparam logic [2:0]         DIV_FIVE   = 3'd5;

endpackage

// ----- sv/dust_sensor_low_pulse_occupancy_top.sv -----
// Low-pulse occupancy meter for a dust sensor. One input transfer is one
// microsecond tick carrying the sensor level (tdata bit 0 set when the output is low).
// A tick that does not close the window is taken without a stall. The tick that
// closes the window starts the result calculation, and the input stalls until the
// result is loaded: two passes of the one-bit-per-cycle restoring divider (ratio,
// then the final divide by five) and two passes of the one-bit-per-cycle multiplier
// (ratio squared and cubed). The result sits in an output register, so ticks keep
// flowing while it waits to be taken; a second window result stalls only if the
// first one is still held.
module dust_sensor_low_pulse_occupancy_top #(
  parameter int unsigned COUNTER_WIDTH = 26
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // [0] pin_low, [7:1] zero
  input  logic [lpo_pkg::TDATA_I_W-1:0]     s_axis_tdata,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // [25:0] low_total, [48:26] ratio_pct_q16, [77:49] concentration_q8, [79:78] zero
  output logic [lpo_pkg::TDATA_O_W-1:0]     m_axis_tdata,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [lpo_pkg::WIN_W-1:0]         cfg_data
);
  import lpo_pkg::*;

  localparam int unsigned CW = COUNTER_WIDTH;
  localparam int unsigned NW = CW + 23;
  localparam int unsigned PW = CW + 7;

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_PCT  = 4'd1;
  localparam logic [3:0] ST_NUM  = 4'd2;
  localparam logic [3:0] ST_WD1  = 4'd3;
  localparam logic [3:0] ST_SQ   = 4'd4;
  localparam logic [3:0] ST_WSQ  = 4'd5;
  localparam logic [3:0] ST_CU   = 4'd6;
  localparam logic [3:0] ST_WCU  = 4'd7;
  localparam logic [3:0] ST_P1   = 4'd8;
  localparam logic [3:0] ST_P2   = 4'd9;
  localparam logic [3:0] ST_NG   = 4'd10;
  localparam logic [3:0] ST_SB   = 4'd11;
  localparam logic [3:0] ST_D2   = 4'd12;
  localparam logic [3:0] ST_WD2  = 4'd13;
  localparam logic [3:0] ST_OUT  = 4'd14;

  logic [3:0]             state_q, state_d;
  logic                   tick;
  logic                   close;
  logic [CW-1:0]          low_cnt;
  logic [CW-1:0]          weff;

  logic [CW-1:0]          l_q;
  logic [CW-1:0]          w_q;
  logic [PW-1:0]          p_q;
  logic [RATIO_W-1:0]     ratio_q;
  logic [R2_W-1:0]        r2_q;
  logic [R3_W-1:0]        r3_q;
  logic [S_W-1:0]         pos_q;
  logic [S_W-1:0]         neg_q;
  logic [S_W-1:0]         s_q;
  logic [CONC_W-1:0]      conc_q;
  logic [TDATA_O_W-1:0]   m_data_q;
  logic                   m_valid_q;

  logic [PW-1:0]          l_ext;
  logic [NW-1:0]          num1;
  logic [S_W-1:0]         s_round;
  logic [S_W-1:0]         r3_ext, r2_ext, ratio_ext;
  logic [CW+LOW_W-1:0]    low_wide;
  logic                   load_out;

  logic                   div_start, div_done, div_ovf;
  logic [NW-1:0]          div_num;
  logic [CW-1:0]          div_den;
  logic [QUO_W-1:0]       div_quo;
  logic                   mul_start, mul_done;
  logic [R2_W-1:0]        mul_a;
  logic [PROD_W-1:0]      mul_prod;

  assign tick      = s_axis_tvalid & s_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign cfg_ready = 1'b1;

  lpo_count #(
    .COUNTER_WIDTH(CW)
  ) u_count (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .tick_i      (tick),
    .pin_i       (s_axis_tdata[0]),
    .cfg_valid_i (cfg_valid),
    .cfg_data_i  (cfg_data),
    .close_o     (close),
    .low_o       (low_cnt),
    .weff_o      (weff)
  );

  // ratio numerator: low * 100 * 2^16 plus half the window for rounding
  assign l_ext     = PW'(l_q);
  assign num1      = {p_q, {FRAC_W{1'b0}}} + NW'(w_q >> 1);
  assign s_round   = s_q + ROUND_HALF;
  assign r3_ext    = S_W'(r3_q);
  assign r2_ext    = S_W'(r2_q);
  assign ratio_ext = S_W'(ratio_q);

  assign div_start = (state_q == ST_NUM) || (state_q == ST_D2);
  assign div_num   = (state_q == ST_NUM) ? num1 : NW'(s_round[S_W-1:9]);
  assign div_den   = (state_q == ST_NUM) ? w_q : CW'(DIV_FIVE);

  lpo_div #(
    .COUNTER_WIDTH(CW)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quo_o   (div_quo),
    .ovf_o   (div_ovf)
  );

  assign mul_start = (state_q == ST_SQ) || (state_q == ST_CU);
  assign mul_a     = (state_q == ST_SQ) ? R2_W'(ratio_q) : r2_q;

  lpo_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (ratio_q),
    .done_o  (mul_done),
    .prod_o  (mul_prod)
  );

  assign load_out = (state_q == ST_OUT) && (!m_valid_q || m_axis_tready);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (tick && close) state_d = ST_PCT;
      ST_PCT:  state_d = ST_NUM;
      ST_NUM:  state_d = ST_WD1;
      ST_WD1:  if (div_done) state_d = ST_SQ;
      ST_SQ:   state_d = ST_WSQ;
      ST_WSQ:  if (mul_done) state_d = ST_CU;
      ST_CU:   state_d = ST_WCU;
      ST_WCU:  if (mul_done) state_d = ST_P1;
      ST_P1:   state_d = ST_P2;
      ST_P2:   state_d = ST_NG;
      ST_NG:   state_d = ST_SB;
      ST_SB:   state_d = ST_D2;
      ST_D2:   state_d = ST_WD2;
      ST_WD2:  if (div_done) state_d = ST_OUT;
      ST_OUT:  if (load_out) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      m_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load_out) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (tick && close) begin
          l_q <= low_cnt;
          w_q <= weff;
        end
      end
      ST_PCT: p_q <= (l_ext << 6) + (l_ext << 5) + (l_ext << 2);
      ST_WD1: begin
        if (div_done) begin
          ratio_q <= (div_ovf || div_quo > QUO_W'(PCT_Q16)) ? PCT_Q16
                                                             : div_quo[RATIO_W-1:0];
        end
      end
      ST_WSQ: if (mul_done) r2_q <= mul_prod[FRAC_W +: R2_W];
      ST_WCU: if (mul_done) r3_q <= mul_prod[FRAC_W +: R3_W];
      ST_P1:  pos_q <= (r3_ext << 3) + (r3_ext << 1) + r3_ext;
      // 5200 = 4096 + 1024 + 64 + 16
      ST_P2:  pos_q <= pos_q + (ratio_ext << 12) + (ratio_ext << 10)
                             + (ratio_ext << 6) + (ratio_ext << 4) + OFFSET_Q16;
      ST_NG:  neg_q <= (r2_ext << 5) + (r2_ext << 2) + (r2_ext << 1);
      ST_SB:  s_q <= (pos_q > neg_q) ? (pos_q - neg_q) : '0;
      ST_WD2: if (div_done) conc_q <= div_ovf ? {CONC_W{1'b1}} : div_quo;
      default: ;
    endcase
    if (load_out) begin
      m_data_q <= {{(TDATA_O_W - LOW_W - RATIO_W - CONC_W){1'b0}},
                   conc_q, ratio_q, low_wide[LOW_W-1:0]};
    end
  end

  assign low_wide      = {{LOW_W{1'b0}}, l_q};
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

`ifndef SYNTHESIS
  a_div_done_owned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == ST_WD1 || state_q == ST_WD2))
    else $error("divider finished outside a divide wait state");

  a_mul_done_owned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_done |-> (state_q == ST_WSQ || state_q == ST_WCU))
    else $error("multiplier finished outside a multiply wait state");

  a_ratio_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[48:26] <= PCT_Q16))
    else $error("ratio beyond one hundred percent");

  a_held_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_valid_q && !m_axis_tready) |=> (m_valid_q && $stable(m_data_q)))
    else $error("waiting result overwritten or dropped");
`endif

endmodule

// ----- sv/lpo_count.sv -----
// tick counters, window register and window-close detection
module lpo_count #(
  parameter int unsigned COUNTER_WIDTH = 26
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          tick_i,
  input  logic                          pin_i,
  input  logic                          cfg_valid_i,
  input  logic [lpo_pkg::WIN_W-1:0]     cfg_data_i,
  output logic                          close_o,
  output logic [COUNTER_WIDTH-1:0]      low_o,
  output logic [COUNTER_WIDTH-1:0]      weff_o
);
  import lpo_pkg::*;

  localparam int unsigned CW = COUNTER_WIDTH;
  localparam int unsigned MW = (CW > WIN_W) ? CW : WIN_W;

  logic [WIN_W-1:0] window_q;
  logic [CW-1:0]    low_q, low_d;
  logic [CW-1:0]    elapsed_q, elapsed_d;
  logic [CW-1:0]    elapsed_next;
  logic [MW-1:0]    win_ext, win_cap, win_clamp;

  // limit the window to what the counter can reach, and at least one tick
  always_comb begin
    win_ext   = MW'(window_q);
    win_cap   = MW'({CW{1'b1}});
    win_clamp = (win_ext > win_cap) ? win_cap : win_ext;
    weff_o    = (win_clamp[CW-1:0] == '0) ? CW'(1) : win_clamp[CW-1:0];
  end

  assign elapsed_next = elapsed_q + CW'(1);
  assign low_o        = low_q + CW'(pin_i);
  assign close_o      = (elapsed_next >= weff_o);

  always_comb begin
    low_d     = low_q;
    elapsed_d = elapsed_q;
    if (tick_i) begin
      if (close_o) begin
        low_d     = '0;
        elapsed_d = '0;
      end else begin
        low_d     = low_o;
        elapsed_d = elapsed_next;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q  <= WIN_RESET;
      low_q     <= '0;
      elapsed_q <= '0;
    end else begin
      if (cfg_valid_i) begin
        window_q <= cfg_data_i;
      end
      low_q     <= low_d;
      elapsed_q <= elapsed_d;
    end
  end

endmodule

// ----- sv/lpo_div.sv -----
// bit-serial restoring divider, one quotient bit per cycle, with overflow flag
module lpo_div #(
  parameter int unsigned COUNTER_WIDTH = 26
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  input  logic [COUNTER_WIDTH+22:0]        num_i,
  input  logic [COUNTER_WIDTH-1:0]         den_i,
  output logic                             done_o,
  output logic [lpo_pkg::QUO_W-1:0]        quo_o,
  output logic                             ovf_o
);
  import lpo_pkg::*;

  localparam int unsigned CW    = COUNTER_WIDTH;
  localparam int unsigned NW    = CW + 23;
  localparam int unsigned CNT_W = $clog2(NW + 1);

  logic [NW-1:0]    num_q;
  logic [CW-1:0]    den_q;
  logic [CW-1:0]    rem_q;
  logic [QUO_W-1:0] quo_q;
  logic             ovf_q;
  logic [CNT_W-1:0] cnt_q;
  logic             busy_q;
  logic             done_q;
  logic [CW:0]      trial;
  logic [CW:0]      diff;
  logic             fits;

  assign trial = {rem_q, num_q[NW-1]};
  assign diff  = trial - {1'b0, den_q};
  assign fits  = (trial >= {1'b0, den_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(NW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= num_i;
      den_q <= den_i;
      rem_q <= '0;
      quo_q <= '0;
      ovf_q <= 1'b0;
    end else if (busy_q) begin
      num_q <= {num_q[NW-2:0], 1'b0};
      rem_q <= fits ? diff[CW-1:0] : trial[CW-1:0];
      // a bit falling off the top means the quotient is past its width
      ovf_q <= ovf_q | quo_q[QUO_W-1];
      quo_q <= {quo_q[QUO_W-2:0], fits};
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;
  assign ovf_o  = ovf_q;

endmodule

// ----- sv/lpo_mul.sv -----
// bit-serial shift-add multiplier, one multiplier bit per cycle, msb first
module lpo_mul (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [lpo_pkg::R2_W-1:0]       a_i,
  input  logic [lpo_pkg::RATIO_W-1:0]    b_i,
  output logic                           done_o,
  output logic [lpo_pkg::PROD_W-1:0]     prod_o
);
  import lpo_pkg::*;

  localparam int unsigned CNT_W = $clog2(RATIO_W + 1);

  logic [R2_W-1:0]    a_q;
  logic [RATIO_W-1:0] b_q;
  logic [PROD_W-1:0]  acc_q;
  logic [CNT_W-1:0]   cnt_q;
  logic               busy_q;
  logic               done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(RATIO_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q   <= a_i;
      b_q   <= b_i;
      acc_q <= '0;
    end else if (busy_q) begin
      acc_q <= (acc_q << 1) + (b_q[RATIO_W-1] ? PROD_W'(a_q) : '0);
      b_q   <= {b_q[RATIO_W-2:0], 1'b0};
    end
  end

  assign done_o = done_q;
  assign prod_o = acc_q;

endmodule

// ----- tb/sv/dust_sensor_low_pulse_occupancy_top_tb.sv -----
// testbench for the dust sensor low-pulse occupancy meter: predicted window results checked
module dust_sensor_low_pulse_occupancy_top_tb;
  import lpo_pkg::*;

  localparam int unsigned TICK_TARGET = 1650;
  localparam int unsigned SETTLE      = 240;
  localparam int unsigned IDLE_LIMIT  = 4000;
  localparam logic [WIN_W-1:0]  WIN_MAX  = '1;
  localparam logic [CONC_W-1:0] CONC_MAX = '1;

  typedef struct packed {
    logic [LOW_W-1:0]   low_total;
    logic [RATIO_W-1:0] ratio;
    logic [CONC_W-1:0]  conc;
  } window_result_t;

  logic                 clk_i;
  logic                 rst_ni = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [TDATA_I_W-1:0] s_axis_tdata = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [TDATA_O_W-1:0] m_axis_tdata;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [WIN_W-1:0]     cfg_data = '0;

  // predictor copy of the window register and counters
  logic [WIN_W-1:0] win_len = WIN_RESET;
  logic [WIN_W-1:0] low_count = '0;
  logic [WIN_W-1:0] tick_count = '0;

  bit             pin_samples[$];
  window_result_t expected_windows[$];

  int          fail_count = 0;
  int unsigned ticks_taken = 0;
  int unsigned results_seen = 0;
  int unsigned idle_cycles = 0;
  int unsigned tick_gap, tick_calm, result_hold, result_calm;

  dust_sensor_low_pulse_occupancy_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data)
  );

  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  task automatic flag_error(input string msg);
    fail_count++;
    $display("%s", msg);
  endtask

  // cubic fit 1.1r^3 - 3.8r^2 + 520r + 0.62, worked as ten times c in Q16
  function automatic logic [CONC_W-1:0] fit_concentration(input logic [RATIO_W-1:0] r);
    bit [63:0] rr, r2, r3, pos, neg, s, c;
    rr  = r;
    r2  = (rr * rr) >> FRAC_W;
    r3  = (r2 * rr) >> FRAC_W;
    pos = 11 * r3 + 5200 * rr + OFFSET_Q16;
    neg = 38 * r2;
    s   = (pos > neg) ? pos - neg : 64'd0;
    c   = (s + ROUND_HALF) / 2560;
    return (c > CONC_MAX) ? CONC_MAX : c[CONC_W-1:0];
  endfunction

  task automatic occupancy_tick(input bit pin_low);
    bit [63:0]      w, q;
    window_result_t res;
    w          = (win_len == 0) ? 64'd1 : 64'(win_len);
    tick_count = tick_count + 1'b1;
    low_count  = low_count + pin_low;
    if (tick_count >= w) begin
      q = (64'(low_count) * PCT_Q16 + (w >> 1)) / w;
      if (q > PCT_Q16) q = PCT_Q16;
      res.low_total = low_count;
      res.ratio     = q[RATIO_W-1:0];
      res.conc      = fit_concentration(q[RATIO_W-1:0]);
      expected_windows.push_back(res);
      low_count  = '0;
      tick_count = '0;
    end
  endtask

  // tick driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      tick_gap  = $urandom_range(0, 7);
      tick_calm = 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        occupancy_tick(s_axis_tdata[0]);
        ticks_taken++;
        if (tick_calm != 0) begin
          tick_calm--;
          tick_gap = 0;
        end else begin
          tick_gap = $urandom_range(0, 7);
          if ($urandom_range(0, 31) == 0) tick_calm = $urandom_range(16, 64);
        end
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (tick_gap == 0 && pin_samples.size() != 0) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= TDATA_I_W'(pin_samples.pop_front());
        end else begin
          s_axis_tvalid <= 1'b0;
          if (tick_gap != 0) tick_gap--;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk_i or negedge rst_ni) begin
    window_result_t want;
    logic [LOW_W-1:0]   got_low;
    logic [RATIO_W-1:0] got_ratio;
    logic [CONC_W-1:0]  got_conc;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      result_hold = $urandom_range(0, 7);
      result_calm = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got_low   = m_axis_tdata[LOW_W-1:0];
        got_ratio = m_axis_tdata[LOW_W +: RATIO_W];
        got_conc  = m_axis_tdata[LOW_W+RATIO_W +: CONC_W];
        if (expected_windows.size() == 0) begin
          flag_error($sformatf("result %0d: none expected (low %0d ratio %0d conc %0d)",
                               results_seen, got_low, got_ratio, got_conc));
        end else begin
          want = expected_windows.pop_front();
          if (got_low !== want.low_total)
            flag_error($sformatf("result %0d: low_total %0d, want %0d",
                                 results_seen, got_low, want.low_total));
          if (got_ratio !== want.ratio)
            flag_error($sformatf("result %0d: ratio_pct_q16 %0d, want %0d",
                                 results_seen, got_ratio, want.ratio));
          if (got_conc !== want.conc)
            flag_error($sformatf("result %0d: concentration_q8 %0d, want %0d",
                                 results_seen, got_conc, want.conc));
        end
        results_seen++;
        if (result_calm != 0) begin
          result_calm--;
          result_hold = 0;
        end else begin
          result_hold = $urandom_range(0, 7);
          if ($urandom_range(0, 15) == 0) result_calm = $urandom_range(8, 32);
        end
      end else if (result_hold != 0) begin
        result_hold--;
      end
      m_axis_tready <= (result_hold == 0);
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
        || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("dust_sensor_low_pulse_occupancy_top_tb: done, errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic wait_drained();
    do @(negedge clk_i);
    while (pin_samples.size() != 0 || s_axis_tvalid || expected_windows.size() != 0);
  endtask

  // let the block settle first, then write the window register and the predictor copy
  task automatic set_window(input logic [WIN_W-1:0] value);
    repeat (SETTLE) @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk_i);
    while (!cfg_ready);
    win_len = value;
    cfg_valid <= 1'b0;
  endtask

  initial begin
    int unsigned win, reps, n, dens, pick;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset window is far too long to close: ticks only build up counts
    pin_samples = '{1, 0, 1};
    wait_drained();
    // shrink below the count already held, closes on the next tick with ratio clamped
    set_window(2);
    pin_samples.push_back(1);
    wait_drained();
    set_window(1);
    pin_samples = '{0, 1};
    wait_drained();
    // all low, all high, a third low
    set_window(3);
    pin_samples = '{1, 1, 1, 0, 0, 0, 1, 0, 0};
    wait_drained();
    set_window(WIN_MAX);
    pin_samples = '{1, 0, 1, 1};
    wait_drained();
    set_window(3);
    pin_samples.push_back(0);
    wait_drained();

    while (ticks_taken < TICK_TARGET) begin
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
        // long window left part-filled, the next phase may shrink it
        win = ($urandom_range(0, 3) == 0) ? WIN_MAX : $urandom_range(500, WIN_MAX);
        n   = $urandom_range(5, 40);
      end else begin
        win  = (pick < 8) ? $urandom_range(1, 40) : $urandom_range(41, 300);
        reps = $urandom_range(1, (win <= 40) ? 6 : 2);
        n    = win * reps + $urandom_range(0, win / 2);
      end
      case ($urandom_range(0, 3))
        0:       dens = 0;
        1:       dens = 100;
        default: dens = $urandom_range(1, 99);
      endcase
      set_window(win[WIN_W-1:0]);
      repeat (n) pin_samples.push_back($urandom_range(0, 99) < dens);
      wait_drained();
    end

    repeat (SETTLE) @(posedge clk_i);
    if (fail_count == 0 && expected_windows.size() == 0) begin
      $display("dust_sensor_low_pulse_occupancy_top_tb: done, clean");
    end else begin
      $display("dust_sensor_low_pulse_occupancy_top_tb: done, errors");
    end
    $finish;
  end

endmodule
